// ===== design/gpr_pkg.sv =====
// Shared types, constants and status codes for the g-protocol packet receiver.
`timescale 1ns / 1ps

package gpr_pkg;

    localparam int GPR_PAYLOAD_BYTES = 64;
    localparam int GPR_POS_W         = 7;

    localparam logic [6:0]  GPR_START_BYTE  = 7'h10;
    localparam logic [6:0]  GPR_SIZE_CTRL   = 7'd9;
    localparam logic [6:0]  GPR_SIZE_DATA   = 7'd2;
    localparam logic [15:0] GPR_CHECK_BASE  = 16'haaaa;
    localparam logic [15:0] GPR_SUM_A_INIT  = 16'hffff;
    localparam logic [7:0]  GPR_CTRL_FORCE  = 8'h80;
    localparam logic [7:0]  GPR_SHORT_FLAG  = 8'h40;
    localparam logic [6:0]  GPR_MAX_SHORT   = 7'd63;

    localparam logic [1:0] GPR_ST_OK       = 2'd0;
    localparam logic [1:0] GPR_ST_BAD_HDR  = 2'd1;
    localparam logic [1:0] GPR_ST_BAD_SIZE = 2'd2;
    localparam logic [1:0] GPR_ST_BAD_SUM  = 2'd3;

    typedef enum logic [2:0] {
        t_PH_HUNT   = 3'b001,
        t_PH_HEADER = 3'b010,
        t_PH_DATA   = 3'b100
    } t_phase;

    typedef struct packed {
        logic [15:0] sum_a;
        logic [15:0] sum_b;
    } t_sums;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       done_res;
        logic [1:0] status;
        logic [4:0] packet_type;
        logic [2:0] recv_seq;
        logic [2:0] send_seq;
        logic [6:0] payload_length;
    } t_result;

endpackage

// ===== design/gpr_cksum.sv =====
// One byte step of the 16-bit g-protocol checksum.
`timescale 1ns / 1ps

module gpr_cksum (
    input  gpr_pkg::t_sums                    i_sums,
    input  logic [7:0]                        i_byte,
    input  logic [gpr_pkg::GPR_POS_W-1:0]     i_pos,
    output gpr_pkg::t_sums                    o_sums
);

    logic [15:0] rot_a;
    logic [15:0] add_a;
    logic [15:0] weight;
    logic [15:0] new_b;

    always_comb begin
        rot_a  = {i_sums.sum_a[14:0], i_sums.sum_a[15]};
        add_a  = rot_a + {8'h00, i_byte};
        weight = 16'(gpr_pkg::GPR_PAYLOAD_BYTES) - {9'h000, i_pos};
        new_b  = i_sums.sum_b + (add_a ^ weight);
        o_sums.sum_b = new_b;
        o_sums.sum_a = (add_a <= rot_a) ? (add_a ^ new_b) : add_a;
    end

endmodule

// ===== design/gpr_parse.sv =====
// Packet framing state, header check and per-beat result decision.
`timescale 1ns / 1ps

module gpr_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_rx_byte,
    output logic             o_emit,
    output gpr_pkg::t_result o_result
);

    gpr_pkg::t_phase r_phase, n_phase;
    logic [6:0]      r_byte_index, n_byte_index;
    logic [7:0]      r_header_xor, n_header_xor;
    logic [6:0]      r_size_byte, n_size_byte;
    logic [15:0]     r_check_field, n_check_field;
    logic [7:0]      r_control_byte, n_control_byte;
    gpr_pkg::t_sums  r_sums, n_sums;
    logic [6:0]      r_deliver_length, n_deliver_length;

    gpr_pkg::t_sums  step_sums;
    logic            short_pkt;
    logic [6:0]      pad_len;
    logic [15:0]     expect_sum;

    gpr_cksum u_cksum (
        .i_sums (r_sums),
        .i_byte (i_rx_byte),
        .i_pos  (r_byte_index),
        .o_sums (step_sums)
    );

    always_comb begin
        n_phase          = r_phase;
        n_byte_index     = r_byte_index;
        n_header_xor     = r_header_xor;
        n_size_byte      = r_size_byte;
        n_check_field    = r_check_field;
        n_control_byte   = r_control_byte;
        n_sums           = r_sums;
        n_deliver_length = r_deliver_length;
        o_emit           = 1'b0;
        o_result         = '0;
        short_pkt        = (r_control_byte & gpr_pkg::GPR_SHORT_FLAG) != 8'h00;
        pad_len          = '0;
        expect_sum       = '0;

        case (r_phase)
            gpr_pkg::t_PH_HEADER: begin
                n_header_xor = r_header_xor ^ i_rx_byte;
                case (r_byte_index)
                    7'd0:    n_size_byte = i_rx_byte[6:0];
                    7'd1:    n_check_field = {r_check_field[15:8], i_rx_byte};
                    7'd2:    n_check_field = {i_rx_byte, r_check_field[7:0]};
                    7'd3:    n_control_byte = i_rx_byte;
                    default: ;
                endcase
                n_byte_index = r_byte_index + 7'd1;
                if (r_byte_index >= 7'd4) begin
                    o_emit            = 1'b1;
                    o_result.done_res = 1'b1;
                    n_phase           = gpr_pkg::t_PH_HUNT;
                    if (n_header_xor != 8'h00) begin
                        o_result.status = gpr_pkg::GPR_ST_BAD_HDR;
                    end else if (r_size_byte == gpr_pkg::GPR_SIZE_CTRL) begin
                        o_result.packet_type = r_control_byte[7:3];
                        o_result.recv_seq    = r_control_byte[2:0];
                    end else if (r_size_byte != gpr_pkg::GPR_SIZE_DATA) begin
                        o_result.status = gpr_pkg::GPR_ST_BAD_SIZE;
                    end else begin
                        o_emit            = 1'b0;
                        o_result.done_res = 1'b0;
                        n_phase           = gpr_pkg::t_PH_DATA;
                        n_byte_index      = '0;
                        n_sums.sum_a      = gpr_pkg::GPR_SUM_A_INIT;
                        n_sums.sum_b      = '0;
                        n_deliver_length  = 7'(gpr_pkg::GPR_PAYLOAD_BYTES);
                    end
                end
            end
            gpr_pkg::t_PH_DATA: begin
                n_sums = step_sums;
                if (r_byte_index == 7'd0 && short_pkt) begin
                    if (i_rx_byte >= 8'(gpr_pkg::GPR_PAYLOAD_BYTES)) begin
                        pad_len = '0;
                    end else if (i_rx_byte == 8'h00) begin
                        pad_len = gpr_pkg::GPR_MAX_SHORT;
                    end else begin
                        pad_len = 7'(gpr_pkg::GPR_PAYLOAD_BYTES) - i_rx_byte[6:0];
                    end
                    n_deliver_length = pad_len;
                end
                if (short_pkt ? (r_byte_index >= 7'd1 && r_byte_index <= n_deliver_length)
                              : (r_byte_index < n_deliver_length)) begin
                    o_emit                 = 1'b1;
                    o_result.payload_valid = 1'b1;
                    o_result.payload_byte  = i_rx_byte;
                end
                n_byte_index = r_byte_index + 7'd1;
                if (r_byte_index >= 7'(gpr_pkg::GPR_PAYLOAD_BYTES - 1)) begin
                    expect_sum = gpr_pkg::GPR_CHECK_BASE
                               - (step_sums.sum_a
                                  ^ {8'h00, r_control_byte | gpr_pkg::GPR_CTRL_FORCE});
                    o_emit                  = 1'b1;
                    o_result.done_res       = 1'b1;
                    o_result.status         = (expect_sum == r_check_field)
                                            ? gpr_pkg::GPR_ST_OK : gpr_pkg::GPR_ST_BAD_SUM;
                    o_result.recv_seq       = r_control_byte[2:0];
                    o_result.send_seq       = r_control_byte[5:3];
                    o_result.payload_length = n_deliver_length;
                    n_phase                 = gpr_pkg::t_PH_HUNT;
                end
            end
            default: begin
                n_phase = gpr_pkg::t_PH_HUNT;
                if (i_rx_byte[6:0] == gpr_pkg::GPR_START_BYTE) begin
                    n_phase      = gpr_pkg::t_PH_HEADER;
                    n_byte_index = '0;
                    n_header_xor = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= gpr_pkg::t_PH_HUNT;
            r_byte_index     <= '0;
            r_header_xor     <= '0;
            r_size_byte      <= '0;
            r_check_field    <= '0;
            r_control_byte   <= '0;
            r_sums.sum_a     <= gpr_pkg::GPR_SUM_A_INIT;
            r_sums.sum_b     <= '0;
            r_deliver_length <= 7'(gpr_pkg::GPR_PAYLOAD_BYTES);
        end else if (i_fire) begin
            r_phase          <= n_phase;
            r_byte_index     <= n_byte_index;
            r_header_xor     <= n_header_xor;
            r_size_byte      <= n_size_byte;
            r_check_field    <= n_check_field;
            r_control_byte   <= n_control_byte;
            r_sums           <= n_sums;
            r_deliver_length <= n_deliver_length;
        end
    end

endmodule

// ===== design/g_protocol_packet_receiver.sv =====
// Top level of the g-protocol packet receiver with its result register.
`timescale 1ns / 1ps

// The receiver takes one line byte per beat and can accept a byte in every cycle: the
// framing state, the header check and one step of the running checksum are settled
// in the cycle the byte is accepted, and any result is held in a single output
// register, so each result appears in the cycle after its byte. Input is stalled only
// while that register holds a result that the consumer has not yet taken.

module g_protocol_packet_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic       o_payload_valid,
    output logic [7:0] o_payload_byte,
    output logic       o_done_res,
    output logic [1:0] o_status,
    output logic [4:0] o_packet_type,
    output logic [2:0] o_recv_seq,
    output logic [2:0] o_send_seq,
    output logic [6:0] o_payload_length
);

    logic             fire;
    logic             emit;
    gpr_pkg::t_result result;
    logic             r_out_valid;
    gpr_pkg::t_result r_out;

    assign o_rx_ready = !r_out_valid || i_res_ready;
    assign fire       = i_rx_valid && o_rx_ready;

    gpr_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_rx_byte (i_rx_byte),
        .o_emit    (emit),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out <= result;
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_payload_valid  = r_out.payload_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_done_res       = r_out.done_res;
    assign o_status         = r_out.status;
    assign o_packet_type    = r_out.packet_type;
    assign o_recv_seq       = r_out.recv_seq;
    assign o_send_seq       = r_out.send_seq;
    assign o_payload_length = r_out.payload_length;

`ifndef SYNTH
    a_result_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_payload_valid || o_done_res))
        else $error("Result beat carries neither a payload byte nor a verdict.");

    a_midpacket_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_done_res) |-> (o_status == gpr_pkg::GPR_ST_OK
                                          && o_payload_length == 7'd0))
        else $error("Payload beat carries verdict fields.");

    a_bad_header_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_done_res && o_status == gpr_pkg::GPR_ST_BAD_HDR)
        |-> (!o_payload_valid && o_recv_seq == 3'd0 && o_packet_type == 5'd0))
        else $error("Bad header verdict carries packet fields.");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_payload_length <= 7'(gpr_pkg::GPR_PAYLOAD_BYTES)))
        else $error("Delivered length exceeds the payload size.");
`endif

endmodule
